>>> rtl/mpsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpsr_pkg: shared types and constants for the motor pulse speed regulator
// Item layouts, operation codes, sequence stages and the counter ceiling.
// ----------------------------------------------------------------------------
package mpsr_pkg;

  // Tick counter advances only while at or below this value.
  localparam logic [15:0] COUNT_CEILING = 16'd65000;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SENSE  = 2'd1,
    OP_TARGET = 2'd2
  } op_t;

  // Sequence stages
  typedef enum logic [1:0] {
    STG_START = 2'd0,
    STG_DELAY = 2'd1,
    STG_POWER = 2'd2,
    STG_WAIT  = 2'd3
  } stage_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        sensor_level;
    logic [15:0] target_period;
  } in_item_t;

  typedef struct packed {
    logic        motor_on;
    logic [1:0]  phase;
    logic [15:0] measured_period;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/mpsr_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpsr_stream_if: valid/ready channel
// Carries one item per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface mpsr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/mpsr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpsr_core: regulator state and single-item update
// Applies one item per step and presents the state after that item.
// ----------------------------------------------------------------------------
module mpsr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mpsr_pkg::in_item_t  item,
  output mpsr_pkg::out_item_t result
);

  mpsr_pkg::stage_t stage_reg, stage_reg_next;
  logic        sense_enable, sense_enable_next;
  logic        count_enable, count_enable_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] period_latched, period_latched_next;
  logic [15:0] target_reg, target_reg_next;
  logic [15:0] delay_left, delay_left_next;
  logic [15:0] power_left, power_left_next;
  logic        drive_pin, drive_pin_next;
  logic        slow_mode;

  assign slow_mode = period_latched > target_reg;

  // Next state for the item being applied
  always_comb begin
    stage_reg_next      = stage_reg;
    sense_enable_next   = sense_enable;
    count_enable_next   = count_enable;
    tick_count_next     = tick_count;
    period_latched_next = period_latched;
    target_reg_next     = target_reg;
    delay_left_next     = delay_left;
    power_left_next     = power_left;
    drive_pin_next      = drive_pin;

    case (item.op)
      mpsr_pkg::OP_TICK: begin
        // saturating revolution counter
        if (count_enable && (tick_count <= mpsr_pkg::COUNT_CEILING)) begin
          tick_count_next = tick_count + 16'd1;
        end
        if (slow_mode) begin
          case (stage_reg)
            mpsr_pkg::STG_START: begin
              sense_enable_next = 1'b0;
              count_enable_next = 1'b1;
              delay_left_next   = {2'b00, period_latched[15:2]};
              power_left_next   = {3'b000, period_latched[15:3]};
              stage_reg_next    = mpsr_pkg::STG_DELAY;
            end
            mpsr_pkg::STG_DELAY: begin
              if (delay_left != 16'd0) begin
                delay_left_next = delay_left - 16'd1;
              end else begin
                drive_pin_next = 1'b1;
                stage_reg_next = mpsr_pkg::STG_POWER;
              end
            end
            mpsr_pkg::STG_POWER: begin
              if (power_left != 16'd0) begin
                power_left_next = power_left - 16'd1;
              end else begin
                drive_pin_next    = 1'b0;
                sense_enable_next = 1'b1;
                stage_reg_next    = mpsr_pkg::STG_WAIT;
              end
            end
            default: ;
          endcase
        end else begin
          // fast mode: no power stage; a pulse caught mid-power stalls here
          case (stage_reg)
            mpsr_pkg::STG_START: begin
              sense_enable_next = 1'b0;
              count_enable_next = 1'b1;
              delay_left_next   = {1'b0, period_latched[15:1]};
              stage_reg_next    = mpsr_pkg::STG_DELAY;
            end
            mpsr_pkg::STG_DELAY: begin
              if (delay_left != 16'd0) begin
                delay_left_next = delay_left - 16'd1;
              end else begin
                sense_enable_next = 1'b1;
                stage_reg_next    = mpsr_pkg::STG_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      mpsr_pkg::OP_SENSE: begin
        // revolution mark latches the period and restarts the sequence
        if (sense_enable && !item.sensor_level) begin
          count_enable_next   = 1'b0;
          period_latched_next = tick_count;
          tick_count_next     = 16'd0;
          stage_reg_next      = mpsr_pkg::STG_START;
        end
      end
      mpsr_pkg::OP_TARGET: begin
        target_reg_next = item.target_period;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg      <= mpsr_pkg::STG_START;
      sense_enable   <= 1'b0;
      count_enable   <= 1'b0;
      tick_count     <= 16'd0;
      period_latched <= 16'd0;
      target_reg     <= 16'd0;
      delay_left     <= 16'd0;
      power_left     <= 16'd0;
      drive_pin      <= 1'b0;
    end else if (step) begin
      stage_reg      <= stage_reg_next;
      sense_enable   <= sense_enable_next;
      count_enable   <= count_enable_next;
      tick_count     <= tick_count_next;
      period_latched <= period_latched_next;
      target_reg     <= target_reg_next;
      delay_left     <= delay_left_next;
      power_left     <= power_left_next;
      drive_pin      <= drive_pin_next;
    end
  end

  // State after the item
  assign result.motor_on        = drive_pin_next;
  assign result.phase           = stage_reg_next;
  assign result.measured_period = period_latched_next;

endmodule
`default_nettype wire

>>> rtl/motor_pulse_speed_regulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_pulse_speed_regulator: revolution-timed motor drive sequencer
// Path: an accepted item passes the input reg, then the result reg, which
// holds the result. Throughput: one item per cycle while no held result stalls.
// A held result stalls the input only while status is not ready.
// Reset: synchronous rst clears stage, enables, counters and periods, motor
// off; both pipeline registers are emptied.
// ----------------------------------------------------------------------------
module motor_pulse_speed_regulator (
  input  logic          clk,
  input  logic          rst,
  mpsr_stream_if.sink   cmd,
  mpsr_stream_if.source status
);

  logic                in_valid;
  mpsr_pkg::in_item_t  in_hold;
  logic                out_valid;
  mpsr_pkg::out_item_t out_hold;
  mpsr_pkg::out_item_t result;
  logic                out_free;
  logic                advance;

  assign out_free  = !out_valid || status.ready;
  assign advance   = in_valid && out_free;
  assign cmd.ready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_hold <= cmd.payload;
    end
  end

  mpsr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_hold),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hold <= result;
    end
  end

  assign status.valid   = out_valid;
  assign status.payload = out_hold;

endmodule
`default_nettype wire
